>>> rtl/core/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the script text tokenizer
// Token kinds, character codes, byte classes and the packet that carries
// the results of one input byte from the scanner to the output stage.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Width of the internal line counter; it saturates at all ones.
  localparam int LineBits   = 20;
  // Width of the line field on the result port.
  localparam int TokenLineW = 20;
  // Most results that one input byte can cause.
  localparam int MaxResults = 4;
  localparam int ResIdxW    = $clog2(MaxResults);
  // Depth of the packet queue between scanner and output stage.
  localparam int QueueDepth = 2;

  typedef logic [LineBits-1:0]   line_t;
  typedef logic [TokenLineW-1:0] tok_line_t;

  typedef enum logic [2:0] {
    KindEnd     = 3'd0,
    KindIdent   = 3'd1,
    KindString  = 3'd2,
    KindNumber  = 3'd3,
    KindLBrace  = 3'd4,
    KindRBrace  = 3'd5,
    KindEquals  = 3'd6,
    KindInvalid = 3'd7
  } tok_kind_e;

  // Event codes on the result port.
  localparam logic EvChar = 1'b0;
  localparam logic EvEnd  = 1'b1;

  // Line source of a result: start line of the open token or current line.
  localparam logic LineTok = 1'b0;
  localparam logic LineCur = 1'b1;

  localparam logic [7:0] CharHash      = 8'h23;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharLBrace    = 8'h7B;
  localparam logic [7:0] CharRBrace    = 8'h7D;
  localparam logic [7:0] CharEquals    = 8'h3D;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharDot       = 8'h2E;
  localparam logic [7:0] CharMinus     = 8'h2D;
  localparam logic [7:0] CharPlus      = 8'h2B;
  localparam logic [7:0] CharUnder     = 8'h5F;

  // One result before its line number is filled in.
  typedef struct packed {
    logic      ev;
    tok_kind_e kind;
    logic [7:0] chr;
    logic      line_sel;
  } res_t;

  // All results of one input byte.
  typedef struct packed {
    logic [ResIdxW-1:0]          last_idx;
    res_t [MaxResults-1:0]       res;
    tok_line_t                   line_tok;
    tok_line_t                   line_cur;
  } pkt_t;

  // Queue side seen by the output stage.
  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } head_t;

  function automatic res_t mk_res(logic ev, tok_kind_e kind, logic [7:0] chr,
                                  logic line_sel);
    res_t r;
    r.ev       = ev;
    r.kind     = kind;
    r.chr      = chr;
    r.line_sel = line_sel;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CharSpace) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_ident(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CharUnder) || (b == CharMinus) ||
           (b == CharDot);
  endfunction

  function automatic logic is_num_cont(logic [7:0] b);
    return is_digit(b) || (b == CharDot) || (b == CharMinus) || (b == CharPlus);
  endfunction

endpackage

>>> rtl/core/stt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_front: scanner of the script text tokenizer
// Holds the scan mode and line counters, classifies each accepted byte and
// turns it into one packet of up to four results for the output stage.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    text_byte_i,
  input  logic          end_of_text_i,
  output logic          push_o,
  output stt_pkg::pkt_t pkt_o
);

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeSlash   = 3'd1,
    ModeHash    = 3'd2,
    ModeLineCmt = 3'd3,
    ModeStr     = 3'd4,
    ModeEsc     = 3'd5,
    ModeNum     = 3'd6,
    ModeIdent   = 3'd7
  } mode_e;

  localparam stt_pkg::line_t LineMax = '1;
  localparam stt_pkg::line_t LineOne = stt_pkg::line_t'(1);

  mode_e          mode_q, mode_d;
  stt_pkg::line_t line_q, line_d;
  stt_pkg::line_t tsl_q, tsl_d;

  stt_pkg::res_t [stt_pkg::MaxResults-1:0] res;
  logic [stt_pkg::ResIdxW:0] n;
  logic                      run_idle;
  logic [7:0]                b;

  assign b = text_byte_i;

  // Next state and result list of one byte.
  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    tsl_d    = tsl_q;
    res      = '0;
    n        = '0;
    run_idle = 1'b0;
    if (end_of_text_i) begin
      unique case (mode_q)
        ModeSlash: begin
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
              stt_pkg::KindInvalid, stt_pkg::CharSlash, stt_pkg::LineTok);
          n = n + 1'b1;
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
              stt_pkg::KindInvalid, 8'h00, stt_pkg::LineTok);
          n = n + 1'b1;
        end
        ModeStr: begin
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
              stt_pkg::KindInvalid, 8'h00, stt_pkg::LineTok);
          n = n + 1'b1;
        end
        ModeEsc: begin
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
              stt_pkg::KindInvalid, stt_pkg::CharBackslash, stt_pkg::LineTok);
          n = n + 1'b1;
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
              stt_pkg::KindInvalid, 8'h00, stt_pkg::LineTok);
          n = n + 1'b1;
        end
        ModeNum: begin
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
              stt_pkg::KindNumber, 8'h00, stt_pkg::LineTok);
          n = n + 1'b1;
        end
        ModeIdent: begin
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
              stt_pkg::KindIdent, 8'h00, stt_pkg::LineTok);
          n = n + 1'b1;
        end
        ModeIdle, ModeHash, ModeLineCmt: begin
        end
      endcase
      res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
          stt_pkg::KindEnd, 8'h00, stt_pkg::LineCur);
      n      = n + 1'b1;
      mode_d = ModeIdle;
      line_d = LineOne;
      tsl_d  = LineOne;
    end else begin
      unique case (mode_q)
        ModeIdle: begin
          run_idle = 1'b1;
        end
        ModeSlash: begin
          if (b == stt_pkg::CharSlash) begin
            mode_d = ModeLineCmt;
          end else begin
            res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
                stt_pkg::KindInvalid, stt_pkg::CharSlash, stt_pkg::LineTok);
            n = n + 1'b1;
            res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
                stt_pkg::KindInvalid, 8'h00, stt_pkg::LineTok);
            n        = n + 1'b1;
            run_idle = 1'b1;
          end
        end
        ModeHash, ModeLineCmt: begin
          if (b == stt_pkg::CharNewline) begin
            if (line_q != LineMax) line_d = line_q + 1'b1;
            mode_d = ModeIdle;
          end
        end
        ModeStr: begin
          if (b == stt_pkg::CharQuote) begin
            res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
                stt_pkg::KindString, 8'h00, stt_pkg::LineTok);
            n      = n + 1'b1;
            mode_d = ModeIdle;
          end else if (b == stt_pkg::CharBackslash) begin
            mode_d = ModeEsc;
          end else begin
            if ((b == stt_pkg::CharNewline) && (line_q != LineMax)) begin
              line_d = line_q + 1'b1;
            end
            res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
                stt_pkg::KindString, b, stt_pkg::LineTok);
            n = n + 1'b1;
          end
        end
        ModeEsc: begin
          // The escaped byte is taken literally, a newline included.
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
              stt_pkg::KindString, b, stt_pkg::LineTok);
          n      = n + 1'b1;
          mode_d = ModeStr;
        end
        ModeNum: begin
          if (stt_pkg::is_num_cont(b)) begin
            res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
                stt_pkg::KindNumber, b, stt_pkg::LineTok);
            n = n + 1'b1;
          end else begin
            res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
                stt_pkg::KindNumber, 8'h00, stt_pkg::LineTok);
            n        = n + 1'b1;
            run_idle = 1'b1;
          end
        end
        ModeIdent: begin
          if (stt_pkg::is_ident(b)) begin
            res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
                stt_pkg::KindIdent, b, stt_pkg::LineTok);
            n = n + 1'b1;
          end else begin
            res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
                stt_pkg::KindIdent, 8'h00, stt_pkg::LineTok);
            n        = n + 1'b1;
            run_idle = 1'b1;
          end
        end
      endcase

      // Byte seen with no token open: it may start a new token.
      if (run_idle) begin
        tsl_d  = line_q;
        mode_d = ModeIdle;
        priority if (stt_pkg::is_space(b)) begin
          if ((b == stt_pkg::CharNewline) && (line_q != LineMax)) begin
            line_d = line_q + 1'b1;
          end
        end else if (b == stt_pkg::CharHash) begin
          mode_d = ModeHash;
        end else if (b == stt_pkg::CharSlash) begin
          mode_d = ModeSlash;
        end else if ((b == stt_pkg::CharLBrace) || (b == stt_pkg::CharRBrace) ||
                     (b == stt_pkg::CharEquals)) begin
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
              (b == stt_pkg::CharLBrace) ? stt_pkg::KindLBrace :
              (b == stt_pkg::CharRBrace) ? stt_pkg::KindRBrace : stt_pkg::KindEquals,
              b, stt_pkg::LineCur);
          n = n + 1'b1;
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
              (b == stt_pkg::CharLBrace) ? stt_pkg::KindLBrace :
              (b == stt_pkg::CharRBrace) ? stt_pkg::KindRBrace : stt_pkg::KindEquals,
              8'h00, stt_pkg::LineCur);
          n = n + 1'b1;
        end else if (b == stt_pkg::CharQuote) begin
          mode_d = ModeStr;
        end else if (stt_pkg::is_digit(b) || (b == stt_pkg::CharMinus) ||
                     (b == stt_pkg::CharPlus)) begin
          mode_d = ModeNum;
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
              stt_pkg::KindNumber, b, stt_pkg::LineCur);
          n = n + 1'b1;
        end else if (stt_pkg::is_ident(b)) begin
          mode_d = ModeIdent;
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
              stt_pkg::KindIdent, b, stt_pkg::LineCur);
          n = n + 1'b1;
        end else begin
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvChar,
              stt_pkg::KindInvalid, b, stt_pkg::LineCur);
          n = n + 1'b1;
          res[n[stt_pkg::ResIdxW-1:0]] = stt_pkg::mk_res(stt_pkg::EvEnd,
              stt_pkg::KindInvalid, 8'h00, stt_pkg::LineCur);
          n = n + 1'b1;
        end
      end
    end
  end

  // Packet toward the queue; bytes without results send nothing.
  assign push_o         = accept_i && (n != '0);
  assign pkt_o.last_idx = stt_pkg::ResIdxW'(n - 1'b1);
  assign pkt_o.res      = res;
  assign pkt_o.line_tok = stt_pkg::tok_line_t'(tsl_q);
  assign pkt_o.line_cur = stt_pkg::tok_line_t'(line_q);

  // Scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      line_q <= LineOne;
      tsl_q  <= LineOne;
    end else if (accept_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      tsl_q  <= tsl_d;
    end
  end

  // The line counter starts at one and never wraps to zero.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q != '0) && (tsl_q != '0))
    else $error("line counter reached zero");

  // End of text restarts the scan on line one.
  a_eot_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_text_i) |=>
      ((mode_q == ModeIdle) && (line_q == LineOne) && (tsl_q == LineOne)))
    else $error("scan state not restarted after end of text");

endmodule

>>> rtl/core/stt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_queue: packet queue of the script text tokenizer
// A short first-in first-out queue of result packets that lets the scanner
// and the output stage stall independently.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stt_pkg::pkt_t  pkt_i,
  output logic           full_o,
  output stt_pkg::head_t head_o,
  input  logic           pop_i
);

  localparam int PtrW = (stt_pkg::QueueDepth > 1) ? $clog2(stt_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(stt_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(stt_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(stt_pkg::QueueDepth);

  stt_pkg::pkt_t mem_q [stt_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == CntFull);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.pkt   = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  // Packet storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= pkt_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // No packet is offered to a full queue and nothing is taken from an empty one.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !head_o.valid))
    else $error("packet queue overflow or underflow");

endmodule

>>> rtl/core/stt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_back: output stage of the script text tokenizer
// Walks the results of the head packet into the output register, one result
// a cycle unless the output stalls, and retires the packet after its last one.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stt_pkg::head_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                event_kind_o,
  output logic [2:0]          token_kind_o,
  output logic [7:0]          token_char_o,
  output stt_pkg::tok_line_t  token_line_o,
  output logic                last_result_o
);

  logic [stt_pkg::ResIdxW-1:0] idx_q;
  logic                        out_valid_q;
  logic                        out_free, advance, is_last;
  stt_pkg::res_t               cur;

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = head_i.valid && out_free;
  assign cur      = head_i.pkt.res[idx_q];
  assign is_last  = (idx_q == head_i.pkt.last_idx);
  assign pop_o    = advance && is_last;

  // Result index within the head packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) idx_q <= is_last ? '0 : idx_q + 1'b1;
      if (out_free) out_valid_q <= head_i.valid;
    end
  end

  // Output register; it loads whenever it is free and a packet is at the head.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_kind_o  <= cur.ev;
      token_kind_o  <= cur.kind;
      token_char_o  <= cur.chr;
      token_line_o  <= (cur.line_sel == stt_pkg::LineCur) ? head_i.pkt.line_cur
                                                         : head_i.pkt.line_tok;
      last_result_o <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // The index only moves past zero inside a packet that is present.
  a_idx_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (head_i.valid && (idx_q <= head_i.pkt.last_idx)))
    else $error("result index outside the head packet");

  // A packet leaves the queue only with its last result.
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_o && last_result_o))
    else $error("packet retired without its last result");

endmodule

>>> rtl/core/script_text_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_text_tokenizer_top: streaming lexer for brace-structured script text
// Takes one text byte per transfer and emits token characters and token ends.
// ----------------------------------------------------------------------------
// The block takes one byte per transfer, or an end-of-text transfer, and gives
// zero to four result transfers for it, the last one marked by last_result_o.
// A scanner updates the scan state in the cycle of the input transfer and
// hands the results of that byte as one packet to a two-entry queue; an output
// stage sends them one per cycle through a registered output, unless the
// output is stalled. The sustained rate is thus set by the output register at
// one result per cycle, and the input keeps accepting while the queue has
// room. Results pass through the queue and then the output register before
// they appear.
// ----------------------------------------------------------------------------
module script_text_tokenizer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                event_kind_o,
  output logic [2:0]          token_kind_o,
  output logic [7:0]          token_char_o,
  output stt_pkg::tok_line_t  token_line_o,
  output logic                last_result_o
);

  logic           accept, push, full, pop;
  stt_pkg::pkt_t  pkt;
  stt_pkg::head_t head;

  // An input transfer waits while the queue is full.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  stt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .pkt_o         (pkt)
  );

  stt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pkt_i  (pkt),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  stt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .token_kind_o  (token_kind_o),
    .token_char_o  (token_char_o),
    .token_line_o  (token_line_o),
    .last_result_o (last_result_o)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for script_text_tokenizer_top
// Streams directed and random script text through the lexer one byte per
// transfer. A scoreboard predicts the character and token-end results of
// every accepted byte and checks each result transfer in order. Both sides
// idle and stall at random. The run also holds the output for a long
// stretch and ends with a few tokens spread over several lines.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint CycleLimit  = 200_000;
  localparam int     RandomItems = 290;
  localparam int     HoldCycles  = 150;

  localparam logic [7:0] CharTab  = 8'h09;
  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharZero = "0";
  localparam logic [7:0] CharNine = "9";
  localparam logic [7:0] LowerA   = "a";
  localparam logic [7:0] LowerZ   = "z";
  localparam logic [7:0] UpperA   = "A";
  localparam logic [7:0] UpperZ   = "Z";

  localparam string IdentHead = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_.";
  localparam string IdentBody = "abcxyzABCXYZ0123456789_-.";
  localparam string NumHead   = "0123456789-+";
  localparam string NumBody   = "0123456789.-+";
  localparam string StrBody   = "abcXYZ019 {}=#/-+._,;:!?";

  // Scan states of the predictor.
  typedef enum logic [2:0] {
    ScanIdle,
    ScanSlash,
    ScanHash,
    ScanLineCmt,
    ScanStr,
    ScanEsc,
    ScanNum,
    ScanIdent
  } scan_e;

  typedef struct packed {
    logic               ev;
    stt_pkg::tok_kind_e kind;
    logic [7:0]         chr;
    stt_pkg::tok_line_t ln;
    logic               last;
  } lex_result_t;

  // Predicts the lexer results per accepted byte and checks result transfers.
  class lexer_scoreboard;
    scan_e          mode;
    stt_pkg::line_t line_now;
    stt_pkg::line_t tok_line;
    lex_result_t    expected_q[$];
    int             mismatches;
    int             inputs_seen;
    int             eot_seen;
    int             results_checked;
    int             kind_count[8];

    function new();
      mode            = ScanIdle;
      line_now        = stt_pkg::line_t'(1);
      tok_line        = stt_pkg::line_t'(1);
      mismatches      = 0;
      inputs_seen     = 0;
      eot_seen        = 0;
      results_checked = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit blank(logic [7:0] b);
      return (b == stt_pkg::CharSpace) || (b >= CharTab && b <= CharCr);
    endfunction

    function bit digit(logic [7:0] b);
      return b >= CharZero && b <= CharNine;
    endfunction

    function bit word_char(logic [7:0] b);
      return (b >= LowerA && b <= LowerZ) || (b >= UpperA && b <= UpperZ) || digit(b) ||
             b == stt_pkg::CharUnder || b == stt_pkg::CharMinus || b == stt_pkg::CharDot;
    endfunction

    function void push(logic ev, stt_pkg::tok_kind_e kind, logic [7:0] chr,
                       stt_pkg::line_t ln);
      lex_result_t r;
      r.ev   = ev;
      r.kind = kind;
      r.chr  = chr;
      r.ln   = stt_pkg::tok_line_t'(ln);
      r.last = 1'b0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // The line counter sticks at all ones.
    function void advance_line();
      if (line_now != '1) line_now++;
    endfunction

    // A byte seen while no token is open.
    function void scan_fresh(logic [7:0] b);
      stt_pkg::tok_kind_e k;
      tok_line = line_now;
      if (blank(b)) begin
        if (b == stt_pkg::CharNewline) advance_line();
      end else if (b == stt_pkg::CharHash) begin
        mode = ScanHash;
      end else if (b == stt_pkg::CharSlash) begin
        mode = ScanSlash;
      end else if (b == stt_pkg::CharLBrace || b == stt_pkg::CharRBrace ||
                   b == stt_pkg::CharEquals) begin
        if (b == stt_pkg::CharLBrace) k = stt_pkg::KindLBrace;
        else if (b == stt_pkg::CharRBrace) k = stt_pkg::KindRBrace;
        else k = stt_pkg::KindEquals;
        push(stt_pkg::EvChar, k, b, line_now);
        push(stt_pkg::EvEnd, k, 8'h00, line_now);
      end else if (b == stt_pkg::CharQuote) begin
        mode = ScanStr;
      end else if (digit(b) || b == stt_pkg::CharMinus || b == stt_pkg::CharPlus) begin
        mode = ScanNum;
        push(stt_pkg::EvChar, stt_pkg::KindNumber, b, line_now);
      end else if (word_char(b)) begin
        mode = ScanIdent;
        push(stt_pkg::EvChar, stt_pkg::KindIdent, b, line_now);
      end else begin
        push(stt_pkg::EvChar, stt_pkg::KindInvalid, b, line_now);
        push(stt_pkg::EvEnd, stt_pkg::KindInvalid, 8'h00, line_now);
      end
    endfunction

    function void note_input(logic [7:0] b, logic eot);
      int             first;
      stt_pkg::line_t start;
      lex_result_t    r;
      first = expected_q.size();
      start = tok_line;
      inputs_seen++;
      if (eot) begin
        // Close whatever is open, then the End token on the current line.
        eot_seen++;
        case (mode)
          ScanSlash: begin
            push(stt_pkg::EvChar, stt_pkg::KindInvalid, stt_pkg::CharSlash, start);
            push(stt_pkg::EvEnd, stt_pkg::KindInvalid, 8'h00, start);
          end
          ScanStr: push(stt_pkg::EvEnd, stt_pkg::KindInvalid, 8'h00, start);
          ScanEsc: begin
            push(stt_pkg::EvChar, stt_pkg::KindInvalid, stt_pkg::CharBackslash, start);
            push(stt_pkg::EvEnd, stt_pkg::KindInvalid, 8'h00, start);
          end
          ScanNum:   push(stt_pkg::EvEnd, stt_pkg::KindNumber, 8'h00, start);
          ScanIdent: push(stt_pkg::EvEnd, stt_pkg::KindIdent, 8'h00, start);
          default: ;
        endcase
        push(stt_pkg::EvEnd, stt_pkg::KindEnd, 8'h00, line_now);
        mode     = ScanIdle;
        line_now = stt_pkg::line_t'(1);
        tok_line = stt_pkg::line_t'(1);
      end else begin
        case (mode)
          ScanIdle: scan_fresh(b);
          ScanSlash: begin
            if (b == stt_pkg::CharSlash) begin
              mode = ScanLineCmt;
            end else begin
              push(stt_pkg::EvChar, stt_pkg::KindInvalid, stt_pkg::CharSlash, start);
              push(stt_pkg::EvEnd, stt_pkg::KindInvalid, 8'h00, start);
              mode = ScanIdle;
              scan_fresh(b);
            end
          end
          ScanHash, ScanLineCmt: begin
            if (b == stt_pkg::CharNewline) begin
              advance_line();
              mode = ScanIdle;
            end
          end
          ScanStr: begin
            if (b == stt_pkg::CharQuote) begin
              push(stt_pkg::EvEnd, stt_pkg::KindString, 8'h00, start);
              mode = ScanIdle;
            end else if (b == stt_pkg::CharBackslash) begin
              mode = ScanEsc;
            end else begin
              if (b == stt_pkg::CharNewline) advance_line();
              push(stt_pkg::EvChar, stt_pkg::KindString, b, start);
            end
          end
          // An escaped byte is taken as text; an escaped newline keeps the line.
          ScanEsc: begin
            push(stt_pkg::EvChar, stt_pkg::KindString, b, start);
            mode = ScanStr;
          end
          ScanNum: begin
            if (digit(b) || b == stt_pkg::CharDot || b == stt_pkg::CharMinus ||
                b == stt_pkg::CharPlus) begin
              push(stt_pkg::EvChar, stt_pkg::KindNumber, b, start);
            end else begin
              push(stt_pkg::EvEnd, stt_pkg::KindNumber, 8'h00, start);
              mode = ScanIdle;
              scan_fresh(b);
            end
          end
          // Inside an identifier.
          default: begin
            if (word_char(b)) begin
              push(stt_pkg::EvChar, stt_pkg::KindIdent, b, start);
            end else begin
              push(stt_pkg::EvEnd, stt_pkg::KindIdent, 8'h00, start);
              mode = ScanIdle;
              scan_fresh(b);
            end
          end
        endcase
      end
      // Mark the final result of this byte.
      if (expected_q.size() > first) begin
        r      = expected_q[expected_q.size() - 1];
        r.last = 1'b1;
        expected_q[expected_q.size() - 1] = r;
      end
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic ev, logic [2:0] kind, logic [7:0] chr,
                               stt_pkg::tok_line_t ln, logic last);
      lex_result_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got ev=%0d kind=%0d char=%02h line=%0d last=%0d",
                 $time, ev, kind, chr, ln, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.ev == stt_pkg::EvEnd) kind_count[want.kind]++;
      compare_field("event_kind", 32'(want.ev), 32'(ev));
      compare_field("token_kind", 32'(want.kind), 32'(kind));
      compare_field("token_char", 32'(want.chr), 32'(chr));
      compare_field("token_line", 32'(want.ln), 32'(ln));
      compare_field("last_result", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         text_byte_i;
  logic               end_of_text_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               event_kind_o;
  logic [2:0]         token_kind_o;
  logic [7:0]         token_char_o;
  stt_pkg::tok_line_t token_line_o;
  logic               last_result_o;

  lexer_scoreboard sb;
  bit              tx_idle_en;
  bit              rx_idle_en;
  int              rx_hold;
  longint          cycles;

  script_text_tokenizer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .token_kind_o  (token_kind_o),
    .token_char_o  (token_char_o),
    .token_line_o  (token_line_o),
    .last_result_o (last_result_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Offer one byte, after a random gap when idling is on, until the transfer.
  task automatic send_item(input logic [7:0] b, input logic eot);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b, eot);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eot();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  // One random piece of script text, mostly well formed.
  task automatic send_fragment();
    int pick;
    int n;
    int r;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_item(IdentHead[$urandom_range(0, IdentHead.len() - 1)], 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) send_item(IdentBody[$urandom_range(0, IdentBody.len() - 1)], 1'b0);
    end else if (pick < 36) begin
      send_item(NumHead[$urandom_range(0, NumHead.len() - 1)], 1'b0);
      n = $urandom_range(0, 4);
      repeat (n) send_item(NumBody[$urandom_range(0, NumBody.len() - 1)], 1'b0);
    end else if (pick < 48) begin
      // Quoted string with escapes and line breaks; a few are left open.
      send_item(stt_pkg::CharQuote, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          send_item(stt_pkg::CharBackslash, 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (r == 1) begin
          send_item(stt_pkg::CharNewline, 1'b0);
        end else begin
          send_item(StrBody[$urandom_range(0, StrBody.len() - 1)], 1'b0);
        end
      end
      if ($urandom_range(0, 9) != 0) send_item(stt_pkg::CharQuote, 1'b0);
    end else if (pick < 56) begin
      r = $urandom_range(0, 2);
      if (r == 0) send_item(stt_pkg::CharLBrace, 1'b0);
      else if (r == 1) send_item(stt_pkg::CharRBrace, 1'b0);
      else send_item(stt_pkg::CharEquals, 1'b0);
    end else if (pick < 72) begin
      r = $urandom_range(0, 3);
      if (r == 0) send_item(stt_pkg::CharNewline, 1'b0);
      else if (r == 1) send_item(8'($urandom_range(CharTab, CharCr)), 1'b0);
      else send_item(stt_pkg::CharSpace, 1'b0);
    end else if (pick < 86) begin
      // Hash or double-slash comment with arbitrary body bytes.
      if (pick < 80) begin
        send_item(stt_pkg::CharHash, 1'b0);
      end else begin
        send_item(stt_pkg::CharSlash, 1'b0);
        send_item(stt_pkg::CharSlash, 1'b0);
      end
      n = $urandom_range(0, 4);
      repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
      send_item(stt_pkg::CharNewline, 1'b0);
    end else if (pick < 90) begin
      send_item(stt_pkg::CharSlash, 1'b0);
    end else if (pick < 97) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_eot();
    end
  endtask

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(event_kind_o, token_kind_o, token_char_o, token_line_o, last_result_o);
    end
  end

  // Result side: a random stall per transfer, plus long holds on request.
  initial begin
    int wait_n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end
      wait_n = rx_idle_en ? $urandom_range(0, 9) : 0;
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && rx_hold == 0);
    end
  end

  // Watchdog on the total cycle count.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[script_text_tokenizer_top] ERROR");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int random_start;
    int next_switch;
    int idle_pick;
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    text_byte_i   = 8'h00;
    end_of_text_i = 1'b0;
    out_stall_i   = 1'b0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    rx_hold       = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each token kind, comments, escapes and the odd bytes.
    send_text("k=+9{");
    send_text("\"a\\\n\"}");
    send_text("/x");
    send_text("#\n//\n");
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
    // Open string with a pending backslash at the end of text.
    send_text("\"\\");
    send_eot();
    // Lone slash at the end of text.
    send_text("/");
    send_eot();

    // Hold the output while the input keeps coming, so the block backs up.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold    = HoldCycles;
    repeat (12) send_text("{=");
    wait_drained();

    // Random text, switching the idling pattern every few dozen transfers.
    random_start = sb.inputs_seen;
    next_switch  = random_start;
    while (sb.inputs_seen - random_start < RandomItems) begin
      if (sb.inputs_seen >= next_switch) begin
        idle_pick   = $urandom_range(0, 3);
        tx_idle_en  = (idle_pick & 1) != 0;
        rx_idle_en  = (idle_pick & 2) != 0;
        next_switch = sb.inputs_seen + 40;
      end
      send_fragment();
    end
    send_eot();
    wait_drained();

    // A few tokens across line breaks, then two text ends.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_text("a\n\"s\n\"");
    send_eot();
    send_text("{");
    send_eot();

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d input transfers (%0d text ends), %0d results checked, %0d mismatches.",
             sb.inputs_seen, sb.eot_seen, sb.results_checked, sb.mismatches);
    $display({"Token ends: end %0d, ident %0d, string %0d, number %0d, ",
              "braces %0d/%0d, eq %0d, invalid %0d."},
             sb.kind_count[stt_pkg::KindEnd], sb.kind_count[stt_pkg::KindIdent],
             sb.kind_count[stt_pkg::KindString], sb.kind_count[stt_pkg::KindNumber],
             sb.kind_count[stt_pkg::KindLBrace], sb.kind_count[stt_pkg::KindRBrace],
             sb.kind_count[stt_pkg::KindEquals], sb.kind_count[stt_pkg::KindInvalid]);
    if (sb.mismatches == 0) begin
      $display("[script_text_tokenizer_top] OK");
    end else begin
      $display("[script_text_tokenizer_top] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/script_text_tokenizer_top.sv
test/testbench.sv
